// ===== hw/rtl/mtd_pkg.sv =====
// ----------------------------------------------------------------------------
// mtd_pkg
// Types and fixed constants that the trigger delay modules share.
// ----------------------------------------------------------------------------
package mtd_pkg;

  localparam int CH_W       = 4;
  localparam int SAMPLE_W   = 32;
  localparam int DELAY_W    = 32;
  localparam int SPMS_W     = 24;
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 40;

  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CFG_INDEX_W-1:0] REG_IGNORE = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_SPMS   = 1'b1;

  localparam logic [SPMS_W-1:0] SPMS_RESET = 24'd3145728;

  // Product of a signed delay and an unsigned rate, then one more bit for the rounding add.
  localparam int PROD_W  = DELAY_W + SPMS_W + 1;
  localparam int SUM_W   = PROD_W + 1;
  localparam int WHOLE_W = SUM_W - 32;

  localparam logic [SUM_W-1:0] HALF = SUM_W'(1) << 31;

  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic in_range;
    logic trig_nz;
    logic pass_now;
  } item_ctl_t;

  localparam int CTL_W = $bits(item_ctl_t);

endpackage

// ===== hw/rtl/mtd_ram.sv =====
// ----------------------------------------------------------------------------
// mtd_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module mtd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/mtd_front.sv =====
// ----------------------------------------------------------------------------
// mtd_front
// Accepts requests, converts the delay to samples and classifies each one.
// ----------------------------------------------------------------------------
module mtd_front #(
  parameter int CHANNELS   = 16,
  parameter int COUNT_BITS = 24
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic [mtd_pkg::SPMS_W-1:0]       spms,
  input  logic                             s_tvalid,
  output logic                             s_tready,
  input  logic [mtd_pkg::IN_DATA_W-1:0]    s_tdata,
  input  logic                             q_ready,
  output logic                             push,
  output logic [mtd_pkg::CH_W-1:0]         push_ch,
  output logic [mtd_pkg::SAMPLE_W-1:0]     push_s,
  output logic [COUNT_BITS-1:0]            push_d,
  output mtd_pkg::item_ctl_t               push_ctl
);

  localparam int WW = (mtd_pkg::WHOLE_W > COUNT_BITS ? mtd_pkg::WHOLE_W : COUNT_BITS) + 1;

  logic                                f0_valid;
  logic [mtd_pkg::CH_W-1:0]            f0_ch;
  logic [mtd_pkg::SAMPLE_W-1:0]        f0_s;
  logic signed [mtd_pkg::DELAY_W-1:0]  f0_ms;

  logic                                f1_valid;
  logic [mtd_pkg::CH_W-1:0]            f1_ch;
  logic [mtd_pkg::SAMPLE_W-1:0]        f1_s;
  logic signed [mtd_pkg::PROD_W-1:0]   f1_prod;

  logic                                f1_load;
  logic signed [mtd_pkg::PROD_W-1:0]   prod;
  logic [mtd_pkg::SUM_W-1:0]           sum;
  logic [mtd_pkg::WHOLE_W-1:0]         d_full;
  logic [WW-1:0]                       d_wide;
  logic [WW-1:0]                       d_max;

  assign f1_load  = !f1_valid || q_ready;
  assign s_tready = !f0_valid || f1_load;
  assign push     = f1_valid && q_ready;

  assign prod = f0_ms * $signed({1'b0, spms});

  always_ff @(posedge clk) begin
    if (rst) begin
      f0_valid <= 1'b0;
      f1_valid <= 1'b0;
    end else begin
      if (s_tready) begin
        f0_valid <= s_tvalid;
      end
      if (f1_load) begin
        f1_valid <= f0_valid;
      end
    end
    if (s_tready && s_tvalid) begin
      f0_ch <= s_tdata[mtd_pkg::CH_W-1:0];
      f0_s  <= s_tdata[mtd_pkg::CH_W +: mtd_pkg::SAMPLE_W];
      f0_ms <= s_tdata[mtd_pkg::CH_W + mtd_pkg::SAMPLE_W +: mtd_pkg::DELAY_W];
    end
    if (f1_load && f0_valid) begin
      f1_ch   <= f0_ch;
      f1_s    <= f0_s;
      f1_prod <= prod;
    end
  end

  // The rounded whole part minus one is negative exactly when the sum is below one.
  assign sum    = mtd_pkg::SUM_W'(f1_prod) + mtd_pkg::HALF;
  assign d_full = sum[mtd_pkg::SUM_W-1:32] - mtd_pkg::WHOLE_W'(1);
  assign d_wide = WW'(d_full);
  assign d_max  = WW'({COUNT_BITS{1'b1}});

  always_comb begin
    push_ch           = f1_ch;
    push_s            = f1_s;
    push_d            = (d_wide > d_max) ? COUNT_BITS'(d_max) : COUNT_BITS'(d_wide);
    push_ctl.in_range = (32'(f1_ch) < CHANNELS);
    push_ctl.trig_nz  = (f1_s != '0);
    push_ctl.pass_now = sum[mtd_pkg::SUM_W-1] || (sum[mtd_pkg::SUM_W-2:32] == '0);
  end

endmodule

// ===== hw/rtl/mtd_queue.sv =====
// ----------------------------------------------------------------------------
// mtd_queue
// Short first-in first-out queue between the front and back parts.
// ----------------------------------------------------------------------------
module mtd_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             not_full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             not_empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign not_full  = (count != CW'(DEPTH));
  assign not_empty = (count != '0);
  assign pop_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CW'(1);
      end else if (pop && !push) begin
        count <= count - CW'(1);
      end
    end
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

`ifndef ASSERT_OFF
  a_count_bound : assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH)) else $error("queue count exceeds depth");
  a_no_pop_empty : assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty) else $error("pop from empty queue");
  a_no_push_full : assert property (@(posedge clk) disable iff (rst)
    push |-> not_full) else $error("push into full queue");
`endif

endmodule

// ===== hw/rtl/mtd_back.sv =====
// ----------------------------------------------------------------------------
// mtd_back
// Applies each request to its channel state and registers the result.
// ----------------------------------------------------------------------------
module mtd_back #(
  parameter int CHANNELS   = 16,
  parameter int COUNT_BITS = 24
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              ignore_retrigger,
  input  logic                              q_valid,
  output logic                              q_pop,
  input  logic [mtd_pkg::CH_W-1:0]          q_ch,
  input  logic [mtd_pkg::SAMPLE_W-1:0]      q_s,
  input  logic [COUNT_BITS-1:0]             q_d,
  input  mtd_pkg::item_ctl_t                q_ctl,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [mtd_pkg::OUT_DATA_W-1:0]    m_tdata
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int SW = 1 + COUNT_BITS + 2 * mtd_pkg::SAMPLE_W;
  localparam int PREV_LO = 0;
  localparam int HELD_LO = mtd_pkg::SAMPLE_W;
  localparam int ELAP_LO = 2 * mtd_pkg::SAMPLE_W;
  localparam int PEND_B  = 2 * mtd_pkg::SAMPLE_W + COUNT_BITS;

  logic                            b1_valid;
  logic [mtd_pkg::CH_W-1:0]        b1_ch;
  logic [mtd_pkg::SAMPLE_W-1:0]    b1_s;
  logic [COUNT_BITS-1:0]           b1_d;
  mtd_pkg::item_ctl_t              b1_ctl;

  logic [CHANNELS-1:0]             vld;
  logic                            rd_vld_q;
  logic                            fwd_hit;
  logic [SW-1:0]                   fwd_data;

  logic                            b1_adv;
  logic                            b1_load;
  logic [AW-1:0]                   rd_addr;
  logic [AW-1:0]                   waddr;
  logic                            we;
  logic [SW-1:0]                   rdata;
  logic [SW-1:0]                   cur;
  logic [SW-1:0]                   wdata;
  logic                            vld_rd;

  logic                            cur_pend;
  logic [COUNT_BITS-1:0]           cur_elap;
  logic [mtd_pkg::SAMPLE_W-1:0]    cur_held;
  logic [mtd_pkg::SAMPLE_W-1:0]    cur_prev;
  logic                            new_pend;
  logic [COUNT_BITS-1:0]           new_elap;
  logic [mtd_pkg::SAMPLE_W-1:0]    new_held;
  logic                            trig;
  logic [mtd_pkg::SAMPLE_W-1:0]    result;

  assign b1_adv  = b1_valid && (!m_tvalid || m_tready);
  assign b1_load = !b1_valid || b1_adv;
  assign q_pop   = q_valid && b1_load;
  assign rd_addr = q_pop ? AW'(q_ch) : AW'(b1_ch);
  assign waddr   = AW'(b1_ch);
  assign we      = b1_adv && b1_ctl.in_range;
  assign vld_rd  = (32'(rd_addr) < CHANNELS) ? vld[rd_addr] : 1'b0;

  mtd_ram #(
    .WIDTH(SW),
    .DEPTH(CHANNELS)
  ) u_state (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .raddr(rd_addr),
    .rdata(rdata)
  );

  // A write in the same cycle as the read of that channel is forwarded.
  assign cur      = fwd_hit ? fwd_data : (rd_vld_q ? rdata : '0);
  assign cur_pend = cur[PEND_B];
  assign cur_elap = cur[ELAP_LO +: COUNT_BITS];
  assign cur_held = cur[HELD_LO +: mtd_pkg::SAMPLE_W];
  assign cur_prev = cur[PREV_LO +: mtd_pkg::SAMPLE_W];

  always_comb begin
    new_pend = cur_pend;
    new_elap = cur_elap;
    new_held = cur_held;
    result   = '0;
    trig     = b1_ctl.trig_nz && (cur_prev == '0) && !(ignore_retrigger && cur_pend);
    if (trig) begin
      if (!b1_ctl.pass_now) begin
        new_pend = 1'b1;
        new_elap = '0;
        new_held = b1_s;
      end else begin
        result = b1_s;
      end
    end else if (cur_pend) begin
      if (!b1_ctl.pass_now && (cur_elap == b1_d)) begin
        result   = cur_held;
        new_pend = 1'b0;
      end
      if (cur_elap != {COUNT_BITS{1'b1}}) begin
        new_elap = cur_elap + COUNT_BITS'(1);
      end
    end
    if (!b1_ctl.in_range) begin
      result = '0;
    end
    wdata = {new_pend, new_elap, new_held, b1_s};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b1_valid <= 1'b0;
      m_tvalid <= 1'b0;
      vld      <= '0;
      fwd_hit  <= 1'b0;
      rd_vld_q <= 1'b0;
    end else begin
      if (b1_load) begin
        b1_valid <= q_valid;
      end
      if (b1_adv) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (we) begin
        vld[waddr] <= 1'b1;
      end
      fwd_hit  <= we && (waddr == rd_addr);
      rd_vld_q <= vld_rd;
    end
    fwd_data <= wdata;
    if (q_pop) begin
      b1_ch  <= q_ch;
      b1_s   <= q_s;
      b1_d   <= q_d;
      b1_ctl <= q_ctl;
    end
    if (b1_adv) begin
      m_tdata <= mtd_pkg::OUT_DATA_W'({result, b1_ch});
    end
  end

`ifndef ASSERT_OFF
  a_range_zero : assert property (@(posedge clk) disable iff (rst)
    b1_adv && !b1_ctl.in_range |=> m_tdata[mtd_pkg::CH_W +: mtd_pkg::SAMPLE_W] == '0)
    else $error("channel out of range gave a nonzero result");
  a_rise_src : assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(b1_adv))
    else $error("result appeared without a request behind it");
  a_write_range : assert property (@(posedge clk) disable iff (rst)
    we |-> 32'(b1_ch) < CHANNELS)
    else $error("state write for a channel out of range");
`endif

endmodule

// ===== hw/rtl/multichannel_trigger_delay.sv =====
// ----------------------------------------------------------------------------
// multichannel_trigger_delay
// Per-channel trigger detection with a programmable delay in milliseconds.
// ----------------------------------------------------------------------------
// The block takes one request per clock cycle while its queue has room,
// and gives one result for each, in order, through its output register. A
// front part registers the request, multiplies the delay by the sample rate
// in one registered 32 by 24 bit multiplier and rounds it to samples; a
// four-entry queue then feeds a back part that keeps the channel state in a
// RAM with a registered read port and writes it back from its last stage, so
// that requests on one channel may follow each other in consecutive cycles.
// The channel state reads as zero after reset through one valid bit per
// channel, so no clearing pass is needed.
module multichannel_trigger_delay #(
  parameter int CHANNELS   = 16,
  parameter int COUNT_BITS = 24
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [mtd_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [mtd_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // channel [3:0], sample_in [35:4], delay_ms [67:36], zero fill [71:68]
  input  logic [mtd_pkg::IN_DATA_W-1:0]        s_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // out_channel [3:0], sample_out [35:4], zero fill [39:36]
  output logic [mtd_pkg::OUT_DATA_W-1:0]       m_tdata
);

  localparam int QW = COUNT_BITS + mtd_pkg::SAMPLE_W + mtd_pkg::CH_W + mtd_pkg::CTL_W;

  logic                             ignore_retrigger;
  logic [mtd_pkg::SPMS_W-1:0]       samples_per_ms;

  logic                             push;
  logic [mtd_pkg::CH_W-1:0]         push_ch;
  logic [mtd_pkg::SAMPLE_W-1:0]     push_s;
  logic [COUNT_BITS-1:0]            push_d;
  mtd_pkg::item_ctl_t               push_ctl;
  logic                             q_not_full;
  logic                             q_not_empty;
  logic                             q_pop;
  logic [QW-1:0]                    q_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      ignore_retrigger <= 1'b0;
      samples_per_ms   <= mtd_pkg::SPMS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        mtd_pkg::REG_IGNORE: ignore_retrigger <= cfg_data[0];
        mtd_pkg::REG_SPMS:   samples_per_ms   <= cfg_data[mtd_pkg::SPMS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  mtd_front #(
    .CHANNELS  (CHANNELS),
    .COUNT_BITS(COUNT_BITS)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .spms    (samples_per_ms),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .q_ready (q_not_full),
    .push    (push),
    .push_ch (push_ch),
    .push_s  (push_s),
    .push_d  (push_d),
    .push_ctl(push_ctl)
  );

  mtd_queue #(
    .WIDTH(QW),
    .DEPTH(mtd_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_data({push_d, push_s, push_ch, push_ctl}),
    .not_full (q_not_full),
    .pop      (q_pop),
    .pop_data (q_data),
    .not_empty(q_not_empty)
  );

  mtd_back #(
    .CHANNELS  (CHANNELS),
    .COUNT_BITS(COUNT_BITS)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .ignore_retrigger(ignore_retrigger),
    .q_valid         (q_not_empty),
    .q_pop           (q_pop),
    .q_ch            (q_data[mtd_pkg::CTL_W +: mtd_pkg::CH_W]),
    .q_s             (q_data[mtd_pkg::CTL_W + mtd_pkg::CH_W +: mtd_pkg::SAMPLE_W]),
    .q_d             (q_data[QW-1 -: COUNT_BITS]),
    .q_ctl           (mtd_pkg::item_ctl_t'(q_data[mtd_pkg::CTL_W-1:0])),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata)
  );

endmodule

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the multichannel trigger delay block.
// ----------------------------------------------------------------------------
// A short directed sequence covers the extreme field values, immediate and
// delayed triggers, a restarted delay, an immediate trigger on a channel with a
// pending delay and a trigger blocked by the ignore mode. Random phases follow,
// each setting the registers and an idle and stall pattern. Most items form
// zero/nonzero trigger patterns on a few busy channels with steady delays. A
// scoreboard tracks the per-channel state, works out the result of every
// accepted request and compares each result with the oldest one outstanding.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CHANNELS = 16;
  localparam int COUNT_BITS = 24;
  localparam longint COUNT_MAX = (longint'(1) << COUNT_BITS) - 1;

  typedef struct packed {
    logic [mtd_pkg::CH_W-1:0]     channel;
    logic [mtd_pkg::SAMPLE_W-1:0] sample;
  } trigger_out_t;

  class trigger_delay_board;
    bit                           ignore_retrigger;
    logic [mtd_pkg::SPMS_W-1:0]   samples_per_ms;
    bit                           armed [CHANNELS];
    logic [COUNT_BITS-1:0]        elapsed [CHANNELS];
    logic [mtd_pkg::SAMPLE_W-1:0] held [CHANNELS];
    logic [mtd_pkg::SAMPLE_W-1:0] previous [CHANNELS];
    trigger_out_t                 due_outputs [$];
    int unsigned                  errors;

    function new();
      ignore_retrigger = 1'b0;
      samples_per_ms = mtd_pkg::SPMS_RESET;
      errors = 0;
      for (int c = 0; c < CHANNELS; c++) begin
        armed[c] = 1'b0;
        elapsed[c] = '0;
        held[c] = '0;
        previous[c] = '0;
      end
    endfunction

    function void write_register(logic [mtd_pkg::CFG_INDEX_W-1:0] reg_index,
                                 logic [mtd_pkg::CFG_DATA_W-1:0] value);
      case (reg_index)
        mtd_pkg::REG_IGNORE: ignore_retrigger = value[0];
        mtd_pkg::REG_SPMS: samples_per_ms = value[mtd_pkg::SPMS_W-1:0];
        default: ;
      endcase
    endfunction

    function void take_request(logic [mtd_pkg::CH_W-1:0] channel,
                               logic [mtd_pkg::SAMPLE_W-1:0] sample,
                               logic [mtd_pkg::DELAY_W-1:0] delay_ms);
      longint                       product;
      longint                       wait_len;
      logic [mtd_pkg::SAMPLE_W-1:0] value;
      bit                           allowed;
      int                           c;
      c = int'(channel);
      value = '0;
      product = longint'($signed(delay_ms)) * longint'(samples_per_ms) + (longint'(1) << 31);
      if (product >= 0) begin
        wait_len = product >>> 32;
      end else begin
        wait_len = -((-product) >>> 32);
      end
      wait_len = wait_len - 1;
      if (wait_len < 0) begin
        wait_len = -1;
      end else if (wait_len > COUNT_MAX) begin
        wait_len = COUNT_MAX;
      end
      allowed = !(ignore_retrigger && armed[c]);
      if (sample != '0 && previous[c] == '0 && allowed) begin
        if (wait_len >= 0) begin
          armed[c] = 1'b1;
          elapsed[c] = '0;
          held[c] = sample;
        end else begin
          value = sample;
        end
      end else if (armed[c]) begin
        if (longint'(elapsed[c]) == wait_len) begin
          value = held[c];
          armed[c] = 1'b0;
        end
        if (longint'(elapsed[c]) < COUNT_MAX) begin
          elapsed[c] = elapsed[c] + 1'b1;
        end
      end
      previous[c] = sample;
      due_outputs.push_back('{channel: channel, sample: value});
    endfunction

    function void check_result(logic [mtd_pkg::CH_W-1:0] channel,
                               logic [mtd_pkg::SAMPLE_W-1:0] sample);
      trigger_out_t want;
      if (due_outputs.size() == 0) begin
        $display("%0t: unexpected result, channel %0d sample %h", $time, channel, sample);
        errors++;
      end else begin
        want = due_outputs.pop_front();
        if (channel !== want.channel) begin
          $display("%0t: out_channel expected %0d, actual %0d", $time, want.channel, channel);
          errors++;
        end
        if (sample !== want.sample) begin
          $display("%0t: sample_out expected %h, actual %h", $time, want.sample, sample);
          errors++;
        end
      end
    endfunction
  endclass

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_we = 1'b0;
  logic [mtd_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [mtd_pkg::CFG_DATA_W-1:0]  cfg_data = '0;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [mtd_pkg::IN_DATA_W-1:0]   s_tdata = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [mtd_pkg::OUT_DATA_W-1:0]  m_tdata;

  int unsigned                  send_idle_pct = 0;
  int unsigned                  stall_pct = 0;
  logic [mtd_pkg::SAMPLE_W-1:0] last_sent [CHANNELS];
  trigger_delay_board           board = new;

  multichannel_trigger_delay #(
    .CHANNELS(CHANNELS),
    .COUNT_BITS(COUNT_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata)
  );

  always #4 clk = ~clk;

  always @(negedge clk) begin
    m_tready = ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        board.take_request(s_tdata[mtd_pkg::CH_W-1:0],
                           s_tdata[mtd_pkg::CH_W +: mtd_pkg::SAMPLE_W],
                           s_tdata[mtd_pkg::CH_W+mtd_pkg::SAMPLE_W +: mtd_pkg::DELAY_W]);
      end
      if (m_tvalid && m_tready) begin
        board.check_result(m_tdata[mtd_pkg::CH_W-1:0],
                           m_tdata[mtd_pkg::CH_W +: mtd_pkg::SAMPLE_W]);
      end
    end
  end

  task automatic send_request(input logic [mtd_pkg::CH_W-1:0] channel,
                              input logic [mtd_pkg::SAMPLE_W-1:0] sample,
                              input logic [mtd_pkg::DELAY_W-1:0] delay_ms);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = {{(mtd_pkg::IN_DATA_W-mtd_pkg::CH_W-mtd_pkg::SAMPLE_W-mtd_pkg::DELAY_W){1'b0}},
               delay_ms, sample, channel};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    last_sent[channel] = sample;
    @(negedge clk);
  endtask

  task automatic write_register(input logic [mtd_pkg::CFG_INDEX_W-1:0] reg_index,
                                input logic [mtd_pkg::CFG_DATA_W-1:0] value);
    cfg_we = 1'b1;
    cfg_index = reg_index;
    cfg_data = value;
    board.write_register(reg_index, value);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic settle();
    s_tvalid = 1'b0;
    while (board.due_outputs.size() != 0) @(negedge clk);
  endtask

  function automatic logic [mtd_pkg::DELAY_W-1:0] pick_delay(int unsigned rate);
    longint      ms;
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) begin
      ms = longint'($urandom);
    end else if (roll < 18) begin
      ms = -longint'($urandom_range(1, 1 << 20));
    end else if (roll < 22) begin
      ms = 0;
    end else if (rate == 0) begin
      ms = longint'($urandom_range(0, 1 << 20));
    end else begin
      ms = (longint'($urandom_range(12) + 1) << 32) / longint'(rate)
           + longint'($urandom_range(3));
      if (ms > 64'sh7FFFFFFF) begin
        ms = 64'sh7FFFFFFF;
      end
    end
    return ms[mtd_pkg::DELAY_W-1:0];
  endfunction

  initial begin
    int unsigned                  rate;
    int unsigned                  hot;
    int unsigned                  mode;
    logic [mtd_pkg::DELAY_W-1:0]  chan_delay [CHANNELS];
    logic [mtd_pkg::CH_W-1:0]     ch;
    logic [mtd_pkg::SAMPLE_W-1:0] smp;
    for (int c = 0; c < CHANNELS; c++) begin
      last_sent[c] = '0;
    end
    repeat (4) @(negedge clk);
    rst = 1'b0;

    write_register(mtd_pkg::REG_IGNORE, '0);
    write_register(mtd_pkg::REG_SPMS, mtd_pkg::CFG_DATA_W'(mtd_pkg::SPMS_RESET));
    send_request(4'd0, 32'h7FFFFFFF, 32'h80000000);
    send_request(4'd15, 32'h80000000, 32'h00000000);
    send_request(4'd1, 32'h00000001, 32'h7FFFFFFF);
    send_request(4'd1, 32'h00000000, 32'h7FFFFFFF);
    send_request(4'd2, 32'hFFFFFFFF, 32'h00000555);
    send_request(4'd2, 32'h00000000, 32'h00000555);
    send_request(4'd3, 32'h00010000, 32'h00000AAA);
    send_request(4'd3, 32'h00000000, 32'h00000AAA);
    send_request(4'd3, 32'h00020000, 32'h80000000);
    send_request(4'd3, 32'h00000000, 32'h00000AAA);
    send_request(4'd3, 32'h00000000, 32'h00000AAA);
    send_request(4'd4, 32'h00000005, 32'h00000AAA);
    send_request(4'd4, 32'h00000000, 32'h00000AAA);
    send_request(4'd4, 32'h00000006, 32'h00000AAA);
    send_request(4'd4, 32'h00000000, 32'h00000AAA);
    send_request(4'd4, 32'h00000000, 32'h00000AAA);
    settle();

    write_register(mtd_pkg::REG_IGNORE, mtd_pkg::CFG_DATA_W'(1));
    send_request(4'd5, 32'h00000007, 32'h00000AAA);
    send_request(4'd5, 32'h00000000, 32'h00000AAA);
    send_request(4'd5, 32'h00000008, 32'h00000AAA);
    send_request(4'd5, 32'h00000000, 32'h00000AAA);
    send_request(4'd5, 32'h00000009, 32'h00000AAA);
    send_request(4'd5, 32'h00000000, 32'h00000AAA);
    send_request(4'd5, 32'h00000000, 32'h00000AAA);
    settle();

    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        0: rate = mtd_pkg::SPMS_RESET;
        1: rate = 24'hFFFFFF;
        2: rate = 0;
        3: rate = 65536;
        default: rate = $urandom_range(65536, 16777215);
      endcase
      write_register(mtd_pkg::REG_IGNORE, mtd_pkg::CFG_DATA_W'((phase / 2) % 2));
      write_register(mtd_pkg::REG_SPMS, mtd_pkg::CFG_DATA_W'(rate));
      mode = phase % 4;
      send_idle_pct = (mode == 1) ? 79 : (mode == 3) ? 16 : 0;
      stall_pct = (mode == 2) ? 79 : (mode == 3) ? 16 : 0;
      for (int c = 0; c < CHANNELS; c++) begin
        chan_delay[c] = pick_delay(rate);
      end
      for (int n = 0; n < 185; n++) begin
        if (n % 40 == 0) begin
          hot = $urandom_range(CHANNELS - 3);
        end
        if ($urandom_range(99) < 70) begin
          ch = mtd_pkg::CH_W'(hot + $urandom_range(2));
        end else begin
          ch = mtd_pkg::CH_W'($urandom_range(CHANNELS - 1));
        end
        if ($urandom_range(99) < 5) begin
          chan_delay[ch] = pick_delay(rate);
        end
        if (last_sent[ch] == '0) begin
          smp = ($urandom_range(99) < 60) ? $urandom : '0;
        end else begin
          smp = ($urandom_range(99) < 60) ? '0 : $urandom;
        end
        if ($urandom_range(99) < 8) begin
          case ($urandom_range(2))
            0: smp = 32'h80000000;
            1: smp = 32'h7FFFFFFF;
            default: smp = 32'hFFFFFFFF;
          endcase
        end
        send_request(ch, smp, ($urandom_range(99) < 10) ? $urandom : chan_delay[ch]);
      end
      settle();
    end

    repeat (20) @(negedge clk);
    if (board.errors == 0 && board.due_outputs.size() == 0) begin
      $display("** multichannel_trigger_delay: PASSED **");
    end else begin
      $display("** multichannel_trigger_delay: FAILED **");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("** multichannel_trigger_delay: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/mtd_pkg.sv
hw/rtl/mtd_ram.sv
hw/rtl/mtd_front.sv
hw/rtl/mtd_queue.sv
hw/rtl/mtd_back.sv
hw/rtl/multichannel_trigger_delay.sv
tb/testbench.sv
